// File: src/pngse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pngse_pkg
// Shared types, constants and byte functions of the stored-deflate PNG encoder.
// ----------------------------------------------------------------------------
package pngse_pkg;

    localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT   = 32'hFFFFFFFF;
    localparam logic [15:0] BLOCK_MAX  = 16'd65535;
    localparam logic [16:0] ADLER_MOD  = 17'd65521;
    localparam logic [13:0] CFG_W_RST  = 14'd320;
    localparam logic [13:0] CFG_H_RST  = 14'd200;
    localparam logic        CFG_IDX_W  = 1'b0;
    localparam logic        CFG_IDX_H  = 1'b1;
    localparam logic [5:0]  HDR_LAST   = 6'd42;
    localparam logic [5:0]  BLK_LAST   = 6'd4;
    localparam logic [5:0]  TRL_LAST   = 6'd19;
    localparam int          CMDQ_DEPTH = 4;
    localparam int          CMDQ_AW    = $clog2(CMDQ_DEPTH);

    // command word from the front to the back
    typedef struct packed {
        logic        tonly;   // trailer only, pixel ignored
        logic        fresh;   // first pixel of a file: header first
        logic        filt;    // first pixel of a row: filter byte first
        logic        trail;   // last pixel: trailer after the data
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [13:0] width;
        logic [13:0] height;
    } t_cmd;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_HDR,
        BS_BLK,
        BS_DAT,
        BS_TRL
    } t_bstate;

    // one byte through the reflected CRC-32
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] x;
        x = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            x = (x >> 1) ^ (CRC_POLY & {32{x[0]}});
        end
        return x;
    endfunction

    // file header: signature, IHDR, IDAT length and type, zlib header
    function automatic logic [7:0] hdr_byte(input logic [5:0] idx, input logic [13:0] w,
                                            input logic [13:0] h, input logic [31:0] crc,
                                            input logic [31:0] idat_len);
        logic [7:0] b;
        logic [31:0] nc;
        nc = ~crc;
        case (idx)
            6'd0:  b = 8'h89;
            6'd1:  b = 8'h50;
            6'd2:  b = 8'h4E;
            6'd3:  b = 8'h47;
            6'd4:  b = 8'h0D;
            6'd5:  b = 8'h0A;
            6'd6:  b = 8'h1A;
            6'd7:  b = 8'h0A;
            6'd11: b = 8'h0D;
            6'd12: b = 8'h49;
            6'd13: b = 8'h48;
            6'd14: b = 8'h44;
            6'd15: b = 8'h52;
            6'd18: b = {2'b00, w[13:8]};
            6'd19: b = w[7:0];
            6'd22: b = {2'b00, h[13:8]};
            6'd23: b = h[7:0];
            6'd24: b = 8'h08;
            6'd25: b = 8'h02;
            6'd29: b = nc[31:24];
            6'd30: b = nc[23:16];
            6'd31: b = nc[15:8];
            6'd32: b = nc[7:0];
            6'd33: b = idat_len[31:24];
            6'd34: b = idat_len[23:16];
            6'd35: b = idat_len[15:8];
            6'd36: b = idat_len[7:0];
            6'd37: b = 8'h49;
            6'd38: b = 8'h44;
            6'd39: b = 8'h41;
            6'd40: b = 8'h54;
            6'd41: b = 8'h78;
            6'd42: b = 8'h01;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // trailer: Adler-32, IDAT CRC, IEND chunk
    function automatic logic [7:0] trl_byte(input logic [5:0] idx, input logic [15:0] ah,
                                            input logic [15:0] al, input logic [31:0] crc);
        logic [7:0] b;
        logic [31:0] nc;
        nc = ~crc;
        case (idx)
            6'd0:  b = ah[15:8];
            6'd1:  b = ah[7:0];
            6'd2:  b = al[15:8];
            6'd3:  b = al[7:0];
            6'd4:  b = nc[31:24];
            6'd5:  b = nc[23:16];
            6'd6:  b = nc[15:8];
            6'd7:  b = nc[7:0];
            6'd12: b = 8'h49;
            6'd13: b = 8'h45;
            6'd14: b = 8'h4E;
            6'd15: b = 8'h44;
            6'd16: b = 8'hAE;
            6'd17: b = 8'h42;
            6'd18: b = 8'h60;
            6'd19: b = 8'h82;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: src/pngse_cmdq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pngse_cmdq
// Short command queue between the pixel front and the byte back end.
// ----------------------------------------------------------------------------
module pngse_cmdq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  pngse_pkg::t_cmd   i_cmd,
    output logic              o_full,
    input  logic              i_pop,
    output pngse_pkg::t_cmd   o_cmd,
    output logic              o_empty
);

    pngse_pkg::t_cmd                r_mem [pngse_pkg::CMDQ_DEPTH];
    logic [pngse_pkg::CMDQ_AW-1:0]  r_wr;
    logic [pngse_pkg::CMDQ_AW-1:0]  r_rd;
    logic [pngse_pkg::CMDQ_AW:0]    r_cnt;
    logic                           wr_en;
    logic                           rd_en;

    assign o_full  = (r_cnt == (pngse_pkg::CMDQ_AW+1)'(pngse_pkg::CMDQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) r_wr <= r_wr + 1'b1;
            if (rd_en) r_rd <= r_rd + 1'b1;
            if (wr_en && !rd_en)      r_cnt <= r_cnt + 1'b1;
            else if (rd_en && !wr_en) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

// File: src/pngse_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pngse_front
// Pixel front end: tracks position in the image and classifies each pixel.
// ----------------------------------------------------------------------------
module pngse_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_acc,
    input  logic [7:0]        i_red,
    input  logic [7:0]        i_green,
    input  logic [7:0]        i_blue,
    input  logic [13:0]       i_cfg_w,
    input  logic [13:0]       i_cfg_h,
    output pngse_pkg::t_cmd   o_cmd
);

    logic        r_hdr_sent;
    logic        r_trl_pend;
    logic [13:0] r_col;
    logic [13:0] r_row;
    logic [13:0] r_lat_w;
    logic [13:0] r_lat_h;

    logic        fresh;
    logic [13:0] w_eff;
    logic [13:0] h_eff;
    logic [13:0] col;
    logic [13:0] row;
    logic        last_col;
    logic        last_pix;

    // classify the incoming pixel
    always_comb begin
        fresh    = !r_hdr_sent;
        w_eff    = fresh ? ((i_cfg_w == '0) ? 14'd1 : i_cfg_w) : r_lat_w;
        h_eff    = fresh ? ((i_cfg_h == '0) ? 14'd1 : i_cfg_h) : r_lat_h;
        col      = fresh ? '0 : r_col;
        row      = fresh ? '0 : r_row;
        last_col = (col == w_eff - 14'd1);
        last_pix = last_col && (row == h_eff - 14'd1);

        o_cmd.tonly  = r_trl_pend;
        o_cmd.fresh  = fresh;
        o_cmd.filt   = (col == '0);
        o_cmd.trail  = last_pix && !fresh;
        o_cmd.red    = i_red;
        o_cmd.green  = i_green;
        o_cmd.blue   = i_blue;
        o_cmd.width  = w_eff;
        o_cmd.height = h_eff;
    end

    // position and file state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_sent <= 1'b0;
            r_trl_pend <= 1'b0;
            r_col      <= '0;
            r_row      <= '0;
            r_lat_w    <= '0;
            r_lat_h    <= '0;
        end else if (i_acc) begin
            if (r_trl_pend) begin
                r_trl_pend <= 1'b0;
                r_hdr_sent <= 1'b0;
            end else begin
                r_lat_w <= w_eff;
                r_lat_h <= h_eff;
                if (last_col) begin
                    r_col <= '0;
                    r_row <= row + 14'd1;
                end else begin
                    r_col <= col + 14'd1;
                    r_row <= row;
                end
                if (last_pix) begin
                    r_trl_pend <= fresh;
                    r_hdr_sent <= fresh;
                end else begin
                    r_hdr_sent <= 1'b1;
                end
            end
        end
    end

endmodule

// File: src/pngse_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pngse_back
// Byte back end: sequences header, block headers, image bytes and trailer,
// keeps Adler-32 and CRC-32, and drives the output word register.
// ----------------------------------------------------------------------------
module pngse_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pngse_pkg::t_cmd   i_cmd,
    input  logic              i_q_empty,
    output logic              o_q_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [7:0]        o_out_byte,
    output logic              o_run_end,
    output logic              o_file_end
);

    pngse_pkg::t_bstate r_state, n_state;
    logic [5:0]         r_idx, n_idx;
    logic [1:0]         r_dsel, n_dsel;
    pngse_pkg::t_cmd    r_cmd, n_cmd;
    logic [13:0]        r_bw, n_bw;
    logic [13:0]        r_bh, n_bh;
    logic [29:0]        r_size;
    logic [15:0]        r_nblk;
    logic [31:0]        r_idat_len;
    logic [29:0]        r_img_left, n_img_left;
    logic [15:0]        r_blk_left, n_blk_left;
    logic [15:0]        r_al, n_al;
    logic [15:0]        r_ah, n_ah;
    logic [31:0]        r_crc, n_crc;
    logic               r_ovalid;
    logic [7:0]         r_obyte;
    logic               r_orun;
    logic               r_ofile;

    logic               adv;
    logic               emit;
    logic [7:0]         byte_v;
    logic               crc_en;
    logic               crc_rst;
    logic               last_b;
    logic               file_b;
    logic               do_load;
    logic [15:0]        blen;
    logic               bfinal;
    logic [16:0]        s1, s2;
    logic [15:0]        al_new;
    logic [15:0]        row3;
    logic [30:0]        sz_rnd;
    logic [16:0]        part_sum;
    logic [15:0]        nblk_v;

    assign adv        = !r_ovalid || i_pop;
    assign o_empty    = !r_ovalid;
    assign o_out_byte = r_obyte;
    assign o_run_end  = r_orun;
    assign o_file_end = r_ofile;

    // image size and IDAT length from the latched dimensions, three stages
    always_comb begin
        row3     = {1'b0, r_bw, 1'b0} + {2'b00, r_bw} + 16'd1;
        sz_rnd   = {1'b0, r_size} + 31'(pngse_pkg::BLOCK_MAX) - 31'd1;
        part_sum = {2'b00, sz_rnd[30:16]} + {1'b0, sz_rnd[15:0]};
        if (part_sum >= {pngse_pkg::BLOCK_MAX, 1'b0})
            nblk_v = {1'b0, sz_rnd[30:16]} + 16'd2;
        else if (part_sum >= {1'b0, pngse_pkg::BLOCK_MAX})
            nblk_v = {1'b0, sz_rnd[30:16]} + 16'd1;
        else
            nblk_v = {1'b0, sz_rnd[30:16]};
    end

    always_ff @(posedge i_clk) begin
        r_size     <= {16'd0, r_bh} * {14'd0, row3};
        r_nblk     <= nblk_v;
        r_idat_len <= 32'(r_size) + {14'd0, r_nblk, 2'b00} + 32'(r_nblk) + 32'd6;
    end

    // stored block header fields
    always_comb begin
        bfinal = (r_img_left <= 30'(pngse_pkg::BLOCK_MAX));
        blen   = bfinal ? r_img_left[15:0] : pngse_pkg::BLOCK_MAX;
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_dsel     = r_dsel;
        n_cmd      = r_cmd;
        n_bw       = r_bw;
        n_bh       = r_bh;
        n_img_left = r_img_left;
        n_blk_left = r_blk_left;
        n_al       = r_al;
        n_ah       = r_ah;
        emit       = 1'b0;
        byte_v     = 8'h00;
        crc_en     = 1'b0;
        crc_rst    = 1'b0;
        last_b     = 1'b0;
        file_b     = 1'b0;
        do_load    = 1'b0;
        o_q_pop    = 1'b0;
        s1         = '0;
        s2         = '0;
        al_new     = '0;

        if (adv) begin
            case (r_state)
                pngse_pkg::BS_IDLE: begin
                    do_load = 1'b1;
                end
                pngse_pkg::BS_HDR: begin
                    emit    = 1'b1;
                    byte_v  = pngse_pkg::hdr_byte(r_idx, r_bw, r_bh, r_crc, r_idat_len);
                    crc_en  = (r_idx >= 6'd12 && r_idx <= 6'd28) || (r_idx >= 6'd37);
                    crc_rst = (r_idx == 6'd12) || (r_idx == 6'd37);
                    if (r_idx == pngse_pkg::HDR_LAST) begin
                        n_img_left = r_size;
                        n_blk_left = '0;
                        n_al       = 16'd1;
                        n_ah       = 16'd0;
                        n_dsel     = r_cmd.filt ? 2'd0 : 2'd1;
                        n_state    = pngse_pkg::BS_BLK;
                        n_idx      = '0;
                    end else begin
                        n_idx = r_idx + 6'd1;
                    end
                end
                pngse_pkg::BS_BLK: begin
                    emit   = 1'b1;
                    crc_en = 1'b1;
                    case (r_idx)
                        6'd0:    byte_v = {7'd0, bfinal};
                        6'd1:    byte_v = blen[7:0];
                        6'd2:    byte_v = blen[15:8];
                        6'd3:    byte_v = ~blen[7:0];
                        default: byte_v = ~blen[15:8];
                    endcase
                    if (r_idx == pngse_pkg::BLK_LAST) begin
                        n_blk_left = blen;
                        n_state    = pngse_pkg::BS_DAT;
                        n_idx      = '0;
                    end else begin
                        n_idx = r_idx + 6'd1;
                    end
                end
                pngse_pkg::BS_DAT: begin
                    emit   = 1'b1;
                    crc_en = 1'b1;
                    case (r_dsel)
                        2'd0:    byte_v = 8'h00;
                        2'd1:    byte_v = r_cmd.red;
                        2'd2:    byte_v = r_cmd.green;
                        default: byte_v = r_cmd.blue;
                    endcase
                    n_blk_left = r_blk_left - 16'd1;
                    n_img_left = r_img_left - 30'd1;
                    // Adler-32 update
                    s1     = {1'b0, r_al} + {9'd0, byte_v};
                    al_new = (s1 >= pngse_pkg::ADLER_MOD) ? 16'(s1 - pngse_pkg::ADLER_MOD)
                                                          : s1[15:0];
                    s2     = {1'b0, r_ah} + {1'b0, al_new};
                    n_al   = al_new;
                    n_ah   = (s2 >= pngse_pkg::ADLER_MOD) ? 16'(s2 - pngse_pkg::ADLER_MOD)
                                                          : s2[15:0];
                    if (r_dsel == 2'd3) begin
                        if (r_cmd.trail) begin
                            n_state = pngse_pkg::BS_TRL;
                            n_idx   = '0;
                        end else begin
                            last_b  = 1'b1;
                            do_load = 1'b1;
                        end
                    end else begin
                        n_dsel  = r_dsel + 2'd1;
                        n_state = (n_blk_left == '0) ? pngse_pkg::BS_BLK : pngse_pkg::BS_DAT;
                        n_idx   = '0;
                    end
                end
                pngse_pkg::BS_TRL: begin
                    emit   = 1'b1;
                    byte_v = pngse_pkg::trl_byte(r_idx, r_ah, r_al, r_crc);
                    crc_en = (r_idx < 6'd4);
                    if (r_idx == pngse_pkg::TRL_LAST) begin
                        last_b  = 1'b1;
                        file_b  = 1'b1;
                        do_load = 1'b1;
                    end else begin
                        n_idx = r_idx + 6'd1;
                    end
                end
                default: begin
                    n_state = pngse_pkg::BS_IDLE;
                end
            endcase

            // take the next command word
            if (do_load) begin
                n_idx = '0;
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_cmd;
                    if (i_cmd.tonly) begin
                        n_state = pngse_pkg::BS_TRL;
                    end else if (i_cmd.fresh) begin
                        n_state = pngse_pkg::BS_HDR;
                        n_bw    = i_cmd.width;
                        n_bh    = i_cmd.height;
                    end else begin
                        n_dsel  = i_cmd.filt ? 2'd0 : 2'd1;
                        n_state = (n_blk_left == '0) ? pngse_pkg::BS_BLK : pngse_pkg::BS_DAT;
                    end
                end else begin
                    n_state = pngse_pkg::BS_IDLE;
                end
            end
        end
    end

    // running CRC
    always_comb begin
        n_crc = r_crc;
        if (emit && crc_en) begin
            n_crc = pngse_pkg::crc_byte(crc_rst ? pngse_pkg::CRC_INIT : r_crc, byte_v);
        end
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pngse_pkg::BS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_dsel     <= n_dsel;
        r_cmd      <= n_cmd;
        r_bw       <= n_bw;
        r_bh       <= n_bh;
        r_img_left <= n_img_left;
        r_blk_left <= n_blk_left;
        r_al       <= n_al;
        r_ah       <= n_ah;
        r_crc      <= n_crc;
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (adv) begin
            r_ovalid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_obyte <= byte_v;
            r_orun  <= last_b;
            r_ofile <= file_b;
        end
    end

    // checks
    a_file_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_ofile |-> r_orun)
        else $error("file end without run end");

    a_dat_blk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == pngse_pkg::BS_DAT |-> r_blk_left != '0)
        else $error("image byte outside a stored block");

    a_blk_img: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == pngse_pkg::BS_BLK |-> r_img_left != '0)
        else $error("block header with no image bytes left");

    a_hdr_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == pngse_pkg::BS_HDR |-> r_idx <= pngse_pkg::HDR_LAST)
        else $error("header index out of range");

endmodule

// File: src/png_stored_rgb_encoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_stored_rgb_encoder_unit
// Streams RGB pixels into the bytes of an uncompressed truecolor PNG file.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter in raster order on push/full (word taken when push && !full).
//   File bytes leave on empty/pop, one byte per word; run_end marks the last
//   byte caused by a pixel, file_end the last byte of the file.
//   Width and height are written on the cfg port while the block is idle and
//   are sampled on the first pixel of each file (zero counts as one).
// Throughput: one output byte per cycle while pop is high and work is queued,
//   set by the single output register. A pixel yields 3 bytes, 4 at the start
//   of a row, plus 5 bytes per stored block header, 43 for the file header and
//   20 for the trailer. From an idle back end, a pixel passes the queue
//   and sequencer registers, then its first byte is registered for output.
// A four-word command queue lets pixels enter while bytes still drain; full
// rises when it fills. When the receiver stalls, the current byte holds and
// the back end waits; nothing is lost. Reset clears all sequencing state and
// restores width 320 and height 200.
// ----------------------------------------------------------------------------
module png_stored_rgb_encoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic        o_run_end,
    output logic        o_file_end,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_idx,
    input  logic [13:0] i_cfg_data
);

    logic [13:0]     r_cfg_w;
    logic [13:0]     r_cfg_h;
    pngse_pkg::t_cmd f_cmd;
    pngse_pkg::t_cmd q_cmd;
    logic            acc;
    logic            q_empty;
    logic            q_pop;

    assign acc = push && !full;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= pngse_pkg::CFG_W_RST;
            r_cfg_h <= pngse_pkg::CFG_H_RST;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_idx == pngse_pkg::CFG_IDX_W) r_cfg_w <= i_cfg_data;
            if (i_cfg_idx == pngse_pkg::CFG_IDX_H) r_cfg_h <= i_cfg_data;
        end
    end

    pngse_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .i_cfg_w (r_cfg_w),
        .i_cfg_h (r_cfg_h),
        .o_cmd   (f_cmd)
    );

    pngse_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (acc),
        .i_cmd   (f_cmd),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd),
        .o_empty (q_empty)
    );

    pngse_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (q_cmd),
        .i_q_empty  (q_empty),
        .o_q_pop    (q_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_out_byte (o_out_byte),
        .o_run_end  (o_run_end),
        .o_file_end (o_file_end)
    );

endmodule
